FILE: sv/cow_pkg.sv
// Shared types, codes and defaults for the COW language core.
package cow_pkg;

  localparam int unsigned TAPE_DEPTH_DEF = 32768;
  localparam int unsigned PROG_DEPTH_DEF = 4096;

  // item modes
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_STEP    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // output kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_NUM  = 2'd2;

  // run status
  localparam logic [1:0] RUN_OK  = 2'd0;
  localparam logic [1:0] RUN_END = 2'd1;
  localparam logic [1:0] RUN_ERR = 2'd2;

  // opcodes
  localparam logic [3:0] OP_CLOSE   = 4'd0;
  localparam logic [3:0] OP_PTR_DEC = 4'd1;
  localparam logic [3:0] OP_PTR_INC = 4'd2;
  localparam logic [3:0] OP_EXEC    = 4'd3;
  localparam logic [3:0] OP_IO      = 4'd4;
  localparam logic [3:0] OP_DEC     = 4'd5;
  localparam logic [3:0] OP_INC     = 4'd6;
  localparam logic [3:0] OP_OPEN    = 4'd7;
  localparam logic [3:0] OP_ZERO    = 4'd8;
  localparam logic [3:0] OP_HOLD    = 4'd9;
  localparam logic [3:0] OP_NUM_OUT = 4'd10;
  localparam logic [3:0] OP_READ    = 4'd11;

  typedef struct packed {
    logic accept;
    logic load;
    logic restart;
    logic clr_step;
    logic exec;
    logic scan_rd;
    logic scan_chk;
    logic push;
  } cow_cmd_t;

  typedef struct packed {
    logic halted;
    logic at_end;
    logic clr_done;
    logic exec_scan;
    logic scan_end;
    logic scan_hit;
    logic out_busy;
  } cow_stat_t;

endpackage

FILE: sv/cow_ctrl.sv
// Controller state machine for the COW language core.
module cow_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        mode,
  input  cow_pkg::cow_stat_t stat,
  output cow_pkg::cow_cmd_t  cmd
);
  import cow_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_EXEC     = 7'b0000100,
    ST_SCAN_RD  = 7'b0001000,
    ST_SCAN_CHK = 7'b0010000,
    ST_FINISH   = 7'b0100000,
    ST_SPARE    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   report, report_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    report_next = report;
    cmd         = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = report ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          case (mode)
            MODE_LOAD: begin
              cmd.load   = 1'b1;
              state_next = ST_FINISH;
            end
            MODE_RESTART: begin
              cmd.restart = 1'b1;
              report_next = 1'b1;
              state_next  = ST_CLEAR;
            end
            MODE_STEP: begin
              state_next = (stat.halted || stat.at_end) ? ST_FINISH : ST_EXEC;
            end
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.exec_scan ? ST_SCAN_RD : ST_FINISH;
      end
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = stat.scan_end ? ST_FINISH : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_next   = stat.scan_hit ? ST_FINISH : ST_SCAN_RD;
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      report <= 1'b0;
    end else begin
      state  <= state_next;
      report <= (state == ST_FINISH) ? 1'b0 : report_next;
    end
  end

endmodule

FILE: sv/cow_dp.sv
// Datapath of the COW language core: program store, tape, registers, output stage.
module cow_dp #(
  parameter int unsigned TAPE_DEPTH = cow_pkg::TAPE_DEPTH_DEF,
  parameter int unsigned PROG_DEPTH = cow_pkg::PROG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cow_pkg::cow_cmd_t  cmd,
  output cow_pkg::cow_stat_t stat,
  input  logic [1:0]         in_mode,
  input  logic [3:0]         in_op,
  input  logic [7:0]         in_val,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,
  output logic [1:0]         m_tuser
);
  import cow_pkg::*;

  localparam int TP_W = $clog2(TAPE_DEPTH);
  localparam int PA_W = $clog2(PROG_DEPTH);
  localparam int PC_W = $clog2(PROG_DEPTH + 1);

  logic [3:0] prog [PROG_DEPTH];
  logic [7:0] tape [TAPE_DEPTH];
  logic [3:0] prog_q;
  logic [7:0] tape_q;

  logic [PC_W-1:0] pc, len, scan_j, scan_depth;
  logic [TP_W-1:0] ptr, clr_addr;
  logic [7:0]      held, item_val, res_val;
  logic            held_flag, stepped, scan_fwd, res_used;
  logic [1:0]      halt, res_kind;

  logic [PC_W-1:0] pc_plus, prog_raddr;
  logic [3:0]      eop;
  logic            indirect, bad_op, tw_en;
  logic [7:0]      tw_data;
  logic [1:0]      halt_final;
  logic [PC_W+12:0] pc_ext;

  assign pc_plus  = pc + PC_W'(1);
  assign indirect = (prog_q == OP_EXEC);
  assign eop      = indirect ? tape_q[3:0] : prog_q;
  assign bad_op   = indirect ? ((tape_q == 8'd3) || (tape_q > 8'd11)) : (prog_q > OP_READ);

  assign prog_raddr = !cmd.scan_rd ? pc : (scan_fwd ? scan_j : scan_j - PC_W'(1));

  always_comb begin
    tw_en   = 1'b0;
    tw_data = tape_q;
    if (!bad_op) begin
      case (eop)
        OP_IO:   begin tw_en = (tape_q == 8'd0); tw_data = item_val; end
        OP_DEC:  begin tw_en = 1'b1; tw_data = tape_q - 8'd1; end
        OP_INC:  begin tw_en = 1'b1; tw_data = tape_q + 8'd1; end
        OP_ZERO: begin tw_en = 1'b1; tw_data = 8'd0; end
        OP_HOLD: begin tw_en = held_flag; tw_data = held; end
        OP_READ: begin tw_en = 1'b1; tw_data = item_val; end
        default: tw_en = 1'b0;
      endcase
    end
  end

  assign stat.halted    = (halt != RUN_OK);
  assign stat.at_end    = (pc >= len);
  assign stat.clr_done  = (clr_addr == TP_W'(TAPE_DEPTH - 1));
  assign stat.exec_scan = !bad_op &&
                          ((eop == OP_CLOSE) || ((eop == OP_OPEN) && (tape_q == 8'd0)));
  assign stat.scan_end  = scan_fwd ? (scan_j >= len) : (scan_j == '0);
  assign stat.scan_hit  = (scan_depth == '0) &&
                          (scan_fwd ? (prog_q == OP_CLOSE) : (prog_q == OP_OPEN));
  assign stat.out_busy  = m_tvalid && !m_tready;

  assign halt_final = (stepped && (halt == RUN_OK) && (pc >= len)) ? RUN_END : halt;
  assign pc_ext     = {13'd0, pc};

  // memories
  always_ff @(posedge clk) begin
    prog_q <= prog[prog_raddr[PA_W-1:0]];
    tape_q <= tape[ptr];
    if (cmd.load && (len < PC_W'(PROG_DEPTH))) begin
      prog[len[PA_W-1:0]] <= in_op;
    end
    if (cmd.clr_step) begin
      tape[clr_addr] <= 8'd0;
    end else if (cmd.exec && tw_en) begin
      tape[ptr] <= tw_data;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_val <= in_val;
      res_kind <= KIND_NONE;
      res_val  <= 8'd0;
      res_used <= 1'b0;
      stepped  <= 1'b0;
    end else if (cmd.exec) begin
      stepped <= 1'b1;
      if (!bad_op) begin
        case (eop)
          OP_IO: begin
            if (tape_q == 8'd0) begin
              res_used <= 1'b1;
            end else begin
              res_kind <= KIND_CHAR;
              res_val  <= tape_q;
            end
          end
          OP_NUM_OUT: begin
            res_kind <= KIND_NUM;
            res_val  <= tape_q;
          end
          OP_READ: res_used <= 1'b1;
          default: res_used <= res_used;
        endcase
      end
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      scan_depth <= '0;
      scan_fwd   <= (eop == OP_OPEN);
      scan_j     <= (eop == OP_OPEN) ? pc_plus : pc;
    end else if (cmd.scan_rd) begin
      if (!scan_fwd && !stat.scan_end) begin
        scan_j <= scan_j - PC_W'(1);
      end
    end else if (cmd.scan_chk) begin
      if (scan_fwd) begin
        scan_j <= scan_j + PC_W'(1);
        if (prog_q == OP_OPEN) begin
          scan_depth <= scan_depth + PC_W'(1);
        end else if (prog_q == OP_CLOSE && scan_depth != '0) begin
          scan_depth <= scan_depth - PC_W'(1);
        end
      end else begin
        if (prog_q == OP_CLOSE) begin
          scan_depth <= scan_depth + PC_W'(1);
        end else if (prog_q == OP_OPEN && scan_depth != '0) begin
          scan_depth <= scan_depth - PC_W'(1);
        end
      end
    end
  end

  // machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      len       <= '0;
      ptr       <= '0;
      held      <= 8'd0;
      held_flag <= 1'b0;
      halt      <= RUN_OK;
      clr_addr  <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + TP_W'(1);
      end
      if (cmd.load && (len < PC_W'(PROG_DEPTH))) begin
        len <= len + PC_W'(1);
      end
      if (cmd.restart) begin
        pc        <= '0;
        ptr       <= '0;
        held      <= 8'd0;
        held_flag <= 1'b0;
        halt      <= RUN_OK;
        clr_addr  <= '0;
      end
      if (cmd.accept && (in_mode == MODE_STEP) && (halt == RUN_OK) && (pc >= len)) begin
        halt <= RUN_END;
      end
      if (cmd.exec) begin
        if (bad_op) begin
          halt <= RUN_ERR;
        end else begin
          case (eop)
            OP_CLOSE: pc <= pc;
            OP_OPEN:  if (tape_q != 8'd0) pc <= pc_plus;
            OP_PTR_DEC: begin
              ptr <= (ptr == '0) ? TP_W'(TAPE_DEPTH - 1) : ptr - TP_W'(1);
              pc  <= pc_plus;
            end
            OP_PTR_INC: begin
              ptr <= (ptr == TP_W'(TAPE_DEPTH - 1)) ? '0 : ptr + TP_W'(1);
              pc  <= pc_plus;
            end
            OP_HOLD: begin
              if (!held_flag) held <= tape_q;
              held_flag <= !held_flag;
              pc        <= pc_plus;
            end
            default: pc <= pc_plus;
          endcase
        end
      end
      if (cmd.scan_rd && stat.scan_end) begin
        halt <= RUN_ERR;
      end
      if (cmd.scan_chk && stat.scan_hit) begin
        pc <= scan_fwd ? scan_j + PC_W'(1) : scan_j;
      end
      if (cmd.push) begin
        halt <= halt_final;
      end
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tuser <= res_kind;
      m_tdata <= {pc_ext[12:0], halt_final, res_used, res_val};
    end
  end

endmodule

FILE: sv/cow_language_core.sv
// Top level of the COW language core: controller, datapath and checks.
//
// Channel  Dir  Fields (low bit first)
// s_*      in   tuser: mode[1:0]; tdata: opcode_in[3:0], input_value[11:4], zero[15:12]
// m_*      out  tuser: out_kind[1:0]; tdata: out_value[7:0], input_used[8],
//               run_status[10:9], program_counter[23:11]
//
// One item at a time. Load, halted step and unused mode go from the accept
// straight to the result. A plain step adds an execute state that writes
// back the tape cell already read. A bracket step adds a read and a check
// state per program word walked by the match search, plus a read when the
// search runs off the program unmatched. Reset and each restart run a tape
// clear pass over all TAPE_DEPTH cells, one cell per cycle, with s_tready low.
// A result waiting in the output register stalls only the next completion.
module cow_language_core #(
  parameter int unsigned TAPE_DEPTH = cow_pkg::TAPE_DEPTH_DEF,
  parameter int unsigned PROG_DEPTH = cow_pkg::PROG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // opcode_in[3:0], input_value[11:4], zero pad
  input  logic [1:0]  s_tuser,  // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // out_value, input_used, run_status, program_counter
  output logic [1:0]  m_tuser   // out_kind[1:0]
);
  import cow_pkg::*;

  cow_cmd_t  cmd;
  cow_stat_t stat;

  // sequencing: clear pass, accept, execute, bracket walk, result hand-off
  cow_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  // program store, tape, pointer/pc state and the output register
  cow_dp #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .PROG_DEPTH (PROG_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_mode  (s_tuser),
    .in_op    (s_tdata[3:0]),
    .in_val   (s_tdata[11:4]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // an accepted transaction takes the core out of idle, so input is never taken twice in a row
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken on back-to-back cycles");

  // tape clear pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input ready during tape clear");

  // an error halt never carries output data
  a_err_no_output: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[10:9] == RUN_ERR)) |-> (m_tuser == KIND_NONE))
    else $error("output produced with error status");

  // a walk read never overlaps the check, execute or accept steps
  a_scan_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> !cmd.scan_chk && !cmd.exec && !cmd.accept)
    else $error("scan command overlaps other work");

endmodule
